// ----- rtl/core/wrf_pkg.sv -----
// Shared types and constants of the waveform region-of-interest finder.
`timescale 1ns / 1ps

package wrf_pkg;

  // Longest waveform the block handles; the index fields are 12 bit wide.
  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned LEN_MAX     = (MAX_SAMPLES < 4096) ? MAX_SAMPLES : 4096;

  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned THR_W    = 19;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned CFG_W    = 19;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned RES_FIFO_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_THR = 3'd0,
    CFG_END_THR   = 3'd1,
    CFG_PRE_PAD   = 3'd2,
    CFG_POST_PAD  = 3'd3,
    CFG_SPW       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0] start_thr;
    logic [THR_W-1:0] end_thr;
    logic [IDX_W-1:0] pre_pad;
    logic [IDX_W-1:0] post_pad;
    logic [LEN_W-1:0] spw;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] region_start;
    logic [IDX_W-1:0] region_end;
    logic             is_last;
    logic             no_region;
  } res_t;

  // Result write strobes from the step logic to the result queue.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ----- rtl/core/waveform_roi_finder.sv -----
// Top level of the hysteresis region-of-interest finder for wire waveforms.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------
//  input    | in        | in_valid_i / in_stall_o | sample_i
//  output   | out       | out_valid_o/ out_stall_i| region_start_o, region_end_o,
//           |           |                         | is_last_o, no_region_o
//  config   | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
//  One sample transfer per cycle while in_stall_o is low. A sample is captured
//  in an input register, runs through the region step logic in the next cycle
//  and its results land in the result queue. The last sample of a waveform may
//  produce two results; the queue drains one result per cycle while out_stall_i
//  is low, and in_stall_o rises while the queue holds more than FifoDepth - 4
//  entries, enough room for the item in flight and the next one.
//  Reset clears the tracking state and the queue and loads the register
//  defaults (length 4096, thresholds and pads zero); no clearing pass follows.
//
module waveform_roi_finder
  import wrf_pkg::*;
#(
  parameter int unsigned FifoDepth = RES_FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample stream
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  // result stream
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [IDX_W-1:0]           region_start_o,
  output logic [IDX_W-1:0]           region_end_o,
  output logic                       is_last_o,
  output logic                       no_region_o,
  // register writes
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  cfg_t                       cfg_q;
  logic                       in_xfer;
  logic                       stage_vld_q;
  logic signed [SAMPLE_W-1:0] stage_smp_q;
  push_t                      push;
  res_t                       res0, res1, head;
  logic                       pop;
  logic [CntW-1:0]            fill;

  // Register writes: each register takes the low bits of the write data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_thr <= '0;
      cfg_q.end_thr   <= '0;
      cfg_q.pre_pad   <= '0;
      cfg_q.post_pad  <= '0;
      cfg_q.spw       <= LEN_W'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_THR: cfg_q.start_thr <= cfg_wdata_i[THR_W-1:0];
        CFG_END_THR:   cfg_q.end_thr   <= cfg_wdata_i[THR_W-1:0];
        CFG_PRE_PAD:   cfg_q.pre_pad   <= cfg_wdata_i[IDX_W-1:0];
        CFG_POST_PAD:  cfg_q.post_pad  <= cfg_wdata_i[IDX_W-1:0];
        CFG_SPW:       cfg_q.spw       <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold back new samples while the queue lacks room for four results.
  assign in_stall_o = (fill > CntW'(FifoDepth - 4));
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input register: capture the sample on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stage_smp_q <= sample_i;
    end
  end

  wrf_roi_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stage_vld_q),
    .sample_i (stage_smp_q),
    .cfg_i    (cfg_q),
    .push_o   (push),
    .res0_o   (res0),
    .res1_o   (res1)
  );

  // Advance the queue head on each result transfer.
  assign pop = out_valid_o && !out_stall_i;

  wrf_res_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res0_i  (res0),
    .res1_i  (res1),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .head_o  (head),
    .count_o (fill)
  );

  assign region_start_o = head.region_start;
  assign region_end_o   = head.region_end;
  assign is_last_o      = head.is_last;
  assign no_region_o    = head.no_region;

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_pair_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.second |-> (push.first && !res0.is_last && res1.is_last))
    else $error("paired results out of order");

  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_region_o) |-> is_last_o)
    else $error("empty marker without last flag");
`endif

endmodule

// ----- rtl/core/wrf_roi_core.sv -----
// Region tracking state and single-step hysteresis, padding and merge logic.
`timescale 1ns / 1ps

module wrf_roi_core
  import wrf_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  cfg_t                       cfg_i,
  output push_t                      push_o,
  output res_t                       res0_o,
  output res_t                       res1_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             open_q, open_d;
  logic [IDX_W-1:0] ostart_q, ostart_d;
  logic             pvalid_q, pvalid_d;
  logic [IDX_W-1:0] pstart_q, pstart_d;
  logic [IDX_W-1:0] pend_q, pend_d;

  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] last_idx;
  logic             last;
  logic             closed;
  logic [IDX_W-1:0] close_end;
  logic [LEN_W-1:0] hi_sum;
  logic [IDX_W-1:0] hi, lo;
  logic             merge;
  logic             emit_prev;
  res_t             prev_res, final_res;

  always_comb begin
    // Saturate the waveform length to the supported range.
    len = cfg_i.spw;
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if (len > LEN_W'(LEN_MAX)) begin
      len = LEN_W'(LEN_MAX);
    end
    last_idx = IDX_W'(len - LEN_W'(1));
    last     = (idx_q >= last_idx);

    open_d    = open_q;
    ostart_d  = ostart_q;
    closed    = 1'b0;
    close_end = '0;
    if (!open_q) begin
      if (sample_i > $signed({1'b0, cfg_i.start_thr})) begin
        open_d   = 1'b1;
        ostart_d = idx_q;
      end
    end else if (sample_i < $signed({1'b0, cfg_i.end_thr})) begin
      closed    = 1'b1;
      close_end = idx_q;
      open_d    = 1'b0;
    end
    // Force an open region shut at the end of the waveform.
    if (!closed && open_d && last) begin
      closed    = 1'b1;
      close_end = last_idx;
      open_d    = 1'b0;
    end

    // Pad and clamp the closed region.
    hi_sum = {1'b0, close_end} + {1'b0, cfg_i.post_pad};
    hi     = (hi_sum > {1'b0, last_idx}) ? last_idx : hi_sum[IDX_W-1:0];
    lo     = (ostart_d > cfg_i.pre_pad) ? ostart_d - cfg_i.pre_pad : '0;
    if (lo > hi) begin
      lo = hi;
    end

    merge     = pvalid_q && (lo <= pend_q);
    emit_prev = closed && pvalid_q && !merge;
    prev_res  = '{region_start: pstart_q, region_end: pend_q, is_last: 1'b0,
                  no_region: 1'b0};

    pvalid_d = pvalid_q;
    pstart_d = pstart_q;
    pend_d   = pend_q;
    if (closed) begin
      if (merge) begin
        pend_d = hi;
      end else begin
        pvalid_d = 1'b1;
        pstart_d = lo;
        pend_d   = hi;
      end
    end

    if (pvalid_d) begin
      final_res = '{region_start: pstart_d, region_end: pend_d, is_last: 1'b1,
                    no_region: 1'b0};
    end else begin
      final_res = '{region_start: '0, region_end: '0, is_last: 1'b1,
                    no_region: 1'b1};
    end

    // The older region leaves first when both go out in one step.
    push_o.first  = valid_i && (emit_prev || last);
    push_o.second = valid_i && emit_prev && last;
    res0_o        = emit_prev ? prev_res : final_res;
    res1_o        = final_res;

    if (last) begin
      idx_d    = '0;
      open_d   = 1'b0;
      pvalid_d = 1'b0;
    end else begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      open_q   <= 1'b0;
      ostart_q <= '0;
      pvalid_q <= 1'b0;
      pstart_q <= '0;
      pend_q   <= '0;
    end else if (valid_i) begin
      idx_q    <= idx_d;
      open_q   <= open_d;
      ostart_q <= ostart_d;
      pvalid_q <= pvalid_d;
      pstart_q <= pstart_d;
      pend_q   <= pend_d;
    end
  end

endmodule

// ----- rtl/core/wrf_res_fifo.sv -----
// Result queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps

module wrf_res_fifo
  import wrf_pkg::*;
#(
  parameter int unsigned Depth = RES_FIFO_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  push_t                        push_i,
  input  res_t                         res0_i,
  input  res_t                         res1_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output res_t                         head_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, wr_nx, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] n_push;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_nx  = ptr_inc(wr_q);
    n_push = CntW'(push_i.first) + CntW'(push_i.second);
    wr_d   = wr_q;
    if (push_i.second) begin
      wr_d = ptr_inc(wr_nx);
    end else if (push_i.first) begin
      wr_d = wr_nx;
    end
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + n_push - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i.second) begin
      mem_q[wr_nx] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

// ----- tb/waveform_roi_finder_test.sv -----
// Self-checking testbench for the waveform region-of-interest finder.
`timescale 1ns / 1ps

module waveform_roi_finder_test;
  import wrf_pkg::*;

  localparam int SMP_MAX    = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SMP_MIN    = -(2 ** (SAMPLE_W - 1));
  localparam int THR_TOP    = 2 ** THR_W - 1;
  localparam int PAD_TOP    = 2 ** IDX_W - 1;
  localparam int LEN_TOP    = 2 ** LEN_W - 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_SAMPLES = 1850;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [IDX_W-1:0]           region_start_o;
  logic [IDX_W-1:0]           region_end_o;
  logic                       is_last_o;
  logic                       no_region_o;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i = '0;
  logic [CFG_W-1:0]           cfg_wdata_i = '0;

  waveform_roi_finder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .region_start_o (region_start_o),
    .region_end_o   (region_end_o),
    .is_last_o      (is_last_o),
    .no_region_o    (no_region_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Register copies as the block should hold them; these are the reset defaults.
  logic [THR_W-1:0] thr_open   = '0;
  logic [THR_W-1:0] thr_close  = '0;
  logic [IDX_W-1:0] pad_before = '0;
  logic [IDX_W-1:0] pad_after  = '0;
  logic [LEN_W-1:0] len_reg    = LEN_W'(4096);

  // Region tracking state of the predictor.
  logic [IDX_W-1:0] wf_index   = '0;
  logic             roi_open   = 1'b0;
  logic [IDX_W-1:0] roi_first  = '0;
  logic             held_valid = 1'b0;
  logic [IDX_W-1:0] held_start = '0;
  logic [IDX_W-1:0] held_end   = '0;

  // Regions predicted but not yet seen on the result port, oldest first.
  res_t roi_q[$];

  int errors       = 0;
  int samples_sent = 0;
  int waves_seen   = 0;
  int regions_seen = 0;
  int empties_seen = 0;
  int idle_cycles  = 0;
  int rx_hold      = 0;
  bit tx_fast      = 1'b0;
  bit rx_fast      = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Waveform length after saturation of the length register.
  function automatic int wire_len();
    int n;
    n = int'(len_reg);
    if (n < 1) n = 1;
    if (n > int'(LEN_MAX)) n = int'(LEN_MAX);
    return n;
  endfunction

  function automatic void push_region(input int lo, input int hi, input bit last_r,
                                      input bit empty_r);
    res_t r;
    r.region_start = IDX_W'(lo);
    r.region_end   = IDX_W'(hi);
    r.is_last      = last_r;
    r.no_region    = empty_r;
    roi_q = {roi_q, r};
  endfunction

  // Advance the hysteresis tracker by one accepted sample and queue what it emits.
  function automatic void track_sample(input logic signed [SAMPLE_W-1:0] smp);
    int  n;
    int  i;
    int  sv;
    int  lo;
    int  hi;
    int  close_at;
    bit  last_smp;
    bit  closed;
    n        = wire_len();
    i        = int'(wf_index);
    sv       = smp;
    last_smp = (i >= n - 1);
    closed   = 1'b0;
    close_at = 0;

    // The opening sample is never tested for closing in the same step.
    if (!roi_open) begin
      if (sv > int'(thr_open)) begin
        roi_open  = 1'b1;
        roi_first = wf_index;
      end
    end else if (sv < int'(thr_close)) begin
      closed   = 1'b1;
      close_at = i;
      roi_open = 1'b0;
    end
    // Force a still-open region shut at the end of the waveform.
    if (!closed && roi_open && last_smp) begin
      closed   = 1'b1;
      close_at = n - 1;
      roi_open = 1'b0;
    end

    if (closed) begin
      hi = close_at + int'(pad_after);
      lo = (int'(roi_first) > int'(pad_before)) ? int'(roi_first) - int'(pad_before) : 0;
      if (hi > n - 1) hi = n - 1;
      if (lo > hi) lo = hi;
      // Merge when the padded start reaches back into the held region.
      if (held_valid && lo <= int'(held_end)) begin
        held_end = IDX_W'(hi);
      end else begin
        if (held_valid) push_region(held_start, held_end, 1'b0, 1'b0);
        held_valid = 1'b1;
        held_start = IDX_W'(lo);
        held_end   = IDX_W'(hi);
      end
    end

    if (last_smp) begin
      if (held_valid) push_region(held_start, held_end, 1'b1, 1'b0);
      else push_region(0, 0, 1'b1, 1'b1);
      wf_index   = '0;
      roi_open   = 1'b0;
      held_valid = 1'b0;
    end else begin
      wf_index = wf_index + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: check every transfer against the oldest prediction and draw
  // the receiver stall for the next one.
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string what, input logic [IDX_W-1:0] want_v,
                                      input logic [IDX_W-1:0] got);
    if (got !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got);
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (roi_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected region, expected none, got start %0d end %0d last %0b empty %0b",
                 $time, region_start_o, region_end_o, is_last_o, no_region_o);
      end else begin
        want = roi_q.pop_front();
        check_field("region_start", want.region_start, region_start_o);
        check_field("region_end", want.region_end, region_end_o);
        check_field("is_last", IDX_W'(want.is_last), IDX_W'(is_last_o));
        check_field("no_region", IDX_W'(want.no_region), IDX_W'(no_region_o));
        if (want.is_last) waves_seen++;
        if (want.no_region) empties_seen++;
        else regions_seen++;
      end
      rx_hold = rx_fast ? 0 : $urandom_range(0, 19);
    end
    // Hold the result port off for the drawn number of cycles.
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Drop the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d regions outstanding",
               $time, IDLE_LIMIT, roi_q.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------

  // Send one sample after a random gap; valid stays up across back-to-back transfers.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_sample(smp);
    samples_sent++;
  endtask

  // Stop sending and wait until every predicted region has come out and the
  // pipeline has flushed any sample that produced nothing.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (roi_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_THR: thr_open   = THR_W'(val);
      CFG_END_THR:   thr_close  = THR_W'(val);
      CFG_PRE_PAD:   pad_before = IDX_W'(val);
      CFG_POST_PAD:  pad_after  = IDX_W'(val);
      CFG_SPW:       len_reg    = LEN_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_all(input int t_open, input int t_close, input int p_pre,
                         input int p_post, input int spw);
    settle();
    write_reg(CFG_START_THR, t_open);
    write_reg(CFG_END_THR, t_close);
    write_reg(CFG_PRE_PAD, p_pre);
    write_reg(CFG_POST_PAD, p_post);
    write_reg(CFG_SPW, spw);
  endtask

  function automatic int pick_pad();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(0, PAD_TOP);
      2, 3:    return $urandom_range(6, 40);
      default: return $urandom_range(0, 5);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: zero thresholds, no padding, full-length waveform. A region
  // opens at bin 0, then the length is cut below the current index so the next
  // sample ends the waveform with a clamped region and two results.
  task automatic check_reset_defaults();
    send_sample(SAMPLE_W'(5));
    send_sample(SAMPLE_W'(SMP_MIN));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(SMP_MAX));
    // Pause until the block is drained before retuning mid-waveform.
    settle();
    write_reg(CFG_SPW, 3);
    send_sample(SAMPLE_W'(0));
  endtask

  // Register extremes: unreachable start threshold gives empty waveforms, a
  // length of zero saturates to one, and maximum pads clamp to the waveform.
  task automatic check_extreme_settings();
    set_all(THR_TOP, 0, 0, 0, 0);
    send_sample(SAMPLE_W'(SMP_MAX));
    send_sample(SAMPLE_W'(SMP_MIN));
    set_all(0, THR_TOP, PAD_TOP, PAD_TOP, 0);
    send_sample(SAMPLE_W'(1));
  endtask

  // Hysteresis around both thresholds, samples equal to a threshold, merging
  // of touching padded regions and a region opened at the last sample.
  task automatic check_hysteresis_merge();
    set_all(100, 50, 2, 3, 12);
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(100));
    send_sample(SAMPLE_W'(101));
    send_sample(SAMPLE_W'(50));
    send_sample(SAMPLE_W'(49));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(150));
    send_sample(SAMPLE_W'(SMP_MIN));
    send_sample(SAMPLE_W'(101));
  endtask

  // Start threshold below end threshold: the opening sample would close the
  // region at once, so it must survive its own step.
  task automatic check_open_not_closed();
    set_all(10, 1000, 1, 0, 4);
    send_sample(SAMPLE_W'(500));
    send_sample(SAMPLE_W'(500));
    send_sample(SAMPLE_W'(5));
    send_sample(SAMPLE_W'(2000));
  endtask

  // Oversized length saturates; a region left open when the length is cut
  // closes at the new end with both pads clamped.
  task automatic check_saturated_length();
    set_all(0, 0, PAD_TOP, PAD_TOP, LEN_TOP);
    send_sample(SAMPLE_W'(-5));
    send_sample(SAMPLE_W'(7));
    send_sample(SAMPLE_W'(7));
    settle();
    write_reg(CFG_SPW, 2);
    send_sample(SAMPLE_W'(7));
  endtask

  // Random phases: each picks thresholds, pads, length and idling, then streams
  // samples shaped around the thresholds so regions open, stay and close.
  task automatic run_random_waveforms();
    int target;
    int t_open;
    int t_close;
    int spw;
    int n;
    int k;
    int pick;
    int v;
    logic signed [SAMPLE_W-1:0] smp;
    target = samples_sent + RANDOM_SAMPLES;
    while (samples_sent < target) begin
      case ($urandom_range(0, 9))
        0: begin
          t_open  = $urandom_range(0, THR_TOP);
          t_close = $urandom_range(0, THR_TOP);
        end
        1: begin
          t_open  = $urandom_range(0, 3000);
          t_close = t_open + $urandom_range(1, 3000);
        end
        default: begin
          t_open  = $urandom_range(0, 3000);
          t_close = $urandom_range(0, t_open);
        end
      endcase
      case ($urandom_range(0, 19))
        0:       spw = 0;
        1:       spw = $urandom_range(200, 300);
        2, 3, 4: spw = $urandom_range(33, 100);
        default: spw = $urandom_range(1, 32);
      endcase
      set_all(t_open, t_close, pick_pad(), pick_pad(), spw);
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      n = wire_len();
      k = n * $urandom_range(1, 3) + $urandom_range(0, n - 1);
      if (k > 400) k = 400;
      repeat (k) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          smp = SAMPLE_W'($urandom);
        end else begin
          if (pick < 40) v = int'(thr_open) + 1 + $urandom_range(0, 3000);
          else if (pick < 55) v = int'(thr_close) + $urandom_range(0, 3000);
          else v = int'(thr_close) - 1 - $urandom_range(0, 3000);
          if (v > SMP_MAX) v = SMP_MAX;
          if (v < SMP_MIN) v = SMP_MIN;
          smp = SAMPLE_W'(v);
        end
        send_sample(smp);
        // Now and then drain mid-waveform, sometimes retuning a register there.
        case ($urandom_range(0, 199))
          0: settle();
          1: begin
            settle();
            write_reg(CFG_SPW, $urandom_range(1, 40));
          end
          2: begin
            settle();
            write_reg(CFG_POST_PAD, $urandom_range(0, 8));
          end
          default: ;
        endcase
      end
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_reset_defaults();
    check_extreme_settings();
    check_hysteresis_merge();
    check_open_not_closed();
    check_saturated_length();
    run_random_waveforms();

    // Drain, then give the block time to show any stray result.
    settle();
    repeat (10) @(posedge clk_i);
    if (roi_q.size() != 0) begin
      errors += roi_q.size();
      $display("%0t: %0d predicted regions never came out", $time, roi_q.size());
    end

    $display("Streamed %0d samples over %0d waveforms under varied thresholds, pads and lengths;",
             samples_sent, waves_seen);
    $display("checked %0d regions and %0d empty waveforms, %0d errors.",
             regions_seen, empties_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
